[src/urs_pkg.sv]
// shared types and constants for the ultrasonic ranging sequencer
`timescale 1ns / 1ps

package urs_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHSEL_W = 2;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned CFG_W   = 16;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = OP_W;
  localparam int unsigned OUT_TDATA_W = 48;

  // configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SCALE   = 1'b1;

  // reset values and special distances
  localparam logic [CFG_W-1:0]  TIMEOUT_RST  = 16'd40000;
  localparam logic [CFG_W-1:0]  SCALE_RST    = 16'd11239;
  localparam logic [DIST_W-1:0] DIST_UNKNOWN = 16'hFFFF;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_POLL  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // measurement phase of the active channel
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT_START = 3'd2,
    PH_WAIT_END   = 3'd3,
    PH_COMPLETE   = 3'd4,
    PH_TIMEOUT    = 3'd5
  } phase_t;

  // one accepted input item
  typedef struct packed {
    op_t                operation;
    logic [CHSEL_W-1:0] channel;
    logic               level;
    logic [STAMP_W-1:0] now;
  } in_item_t;

  // one result item, packed so that trigger_fire lands in bit 0
  typedef struct packed {
    logic               read_fresh;
    logic [DIST_W-1:0]  read_distance;
    logic               running;
    logic               done_timeout;
    logic [DIST_W-1:0]  done_distance;
    logic [CHSEL_W-1:0] done_channel;
    logic               done_valid;
    logic [CHSEL_W-1:0] trigger_channel;
    logic               trigger_fire;
  } out_item_t;

endpackage

[src/ultrasonic_ranging_sequencer_core.sv]
// top level of the multi-channel ultrasonic echo ranging sequencer
`timescale 1ns / 1ps

// Takes one item per clock while the output is not stalled: an item is captured
// in an input register, and when it advances one pass of logic (a 16x16 multiply
// for the echo width to distance scaling, the wrap-around timeout compare and the
// channel update) writes the sequencer state and the output register. A result is
// presented from the output register and is taken when out_tready is high; while
// a result waits, one more item is held in the input register and then in_tready
// drops until the result is taken.
// Start re-arms channel 0, echo edges count only on the active channel, a poll
// times out or advances the sequence, and a read returns a stored distance.
// Configuration writes must be made while no item is in flight.
module ultrasonic_ranging_sequencer_core #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [urs_pkg::CFG_W-1:0]           cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: channel[1:0], level[2], now[18:3], zero fill
  input  logic [urs_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tuser: operation[1:0]
  input  logic [urs_pkg::IN_TUSER_W-1:0]      in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: trigger_fire[0], trigger_channel[2:1], done_valid[3],
  // done_channel[5:4], done_distance[21:6], done_timeout[22], running[23],
  // read_distance[39:24], read_fresh[40], zero fill
  output logic [urs_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import urs_pkg::*;

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IDX_W = (CH_W > CHSEL_W) ? CH_W : CHSEL_W;
  localparam int unsigned OUT_W = $bits(out_item_t);

  // configuration registers
  logic [CFG_W-1:0] timeout_r;
  logic [CFG_W-1:0] scale_r;

  // input stage and output stage
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;
  logic       advance;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [CH_W-1:0]        active_r, active_nxt;
  logic                   seq_active_r, seq_active_nxt;
  logic [STAMP_W-1:0]     trig_stamp_r, trig_stamp_nxt;
  logic [STAMP_W-1:0]     echo_stamp_r, echo_stamp_nxt;
  logic [CHANNELS-1:0]    fresh_r, fresh_nxt;
  logic [DIST_W-1:0]      dist_r [CHANNELS];
  logic                   dist_we;
  logic [DIST_W-1:0]      dist_wdata;

  // helpers
  logic [IDX_W-1:0]       ch_ext;
  logic [IDX_W-1:0]       active_ext;
  logic [IDX_W-1:0]       next_ext;
  logic                   ch_in_range;
  logic [CH_W-1:0]        ch_idx;
  logic [CH_W-1:0]        next_ch;
  logic                   last_ch;
  logic [STAMP_W-1:0]     echo_width;
  logic [2*STAMP_W-1:0]   echo_prod;
  logic [STAMP_W-1:0]     elapsed;

  // handshake
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_item_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      scale_r   <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_SCALE:   scale_r   <= cfg_wdata;
        default:     timeout_r <= timeout_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.operation <= op_t'(in_tuser);
      s1_item_r.channel   <= in_tdata[CHSEL_W-1:0];
      s1_item_r.level     <= in_tdata[CHSEL_W];
      s1_item_r.now       <= in_tdata[CHSEL_W+STAMP_W:CHSEL_W+1];
    end
  end

  // index helpers
  assign ch_ext      = IDX_W'(s1_item_r.channel);
  assign active_ext  = IDX_W'(active_r);
  assign ch_in_range = (32'(ch_ext) < CHANNELS);
  assign ch_idx      = CH_W'(ch_ext);
  assign next_ch     = active_r + CH_W'(1);
  assign next_ext    = IDX_W'(next_ch);
  assign last_ch     = (active_r == CH_W'(CHANNELS - 1));

  // echo width to distance, and time since trigger
  assign echo_width = s1_item_r.now - echo_stamp_r;
  assign echo_prod  = echo_width * scale_r;
  assign elapsed    = s1_item_r.now - trig_stamp_r;

  // item processing
  always_comb begin
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    seq_active_nxt = seq_active_r;
    trig_stamp_nxt = trig_stamp_r;
    echo_stamp_nxt = echo_stamp_r;
    fresh_nxt      = fresh_r;
    dist_we        = 1'b0;
    dist_wdata     = DIST_UNKNOWN;
    out_item_nxt   = '0;

    case (s1_item_r.operation)
      OP_START: begin
        active_nxt     = '0;
        seq_active_nxt = 1'b1;
        fresh_nxt      = '0;
        phase_nxt      = PH_WAIT_START;
        trig_stamp_nxt = s1_item_r.now;
        out_item_nxt.trigger_fire    = 1'b1;
        out_item_nxt.trigger_channel = '0;
      end
      OP_EDGE: begin
        if (seq_active_r && ch_in_range && (ch_ext == active_ext)) begin
          if (s1_item_r.level) begin
            if (phase_r == PH_WAIT_START) begin
              echo_stamp_nxt = s1_item_r.now;
              phase_nxt      = PH_WAIT_END;
            end
          end else if (phase_r == PH_WAIT_END) begin
            dist_we                    = 1'b1;
            dist_wdata                 = echo_prod[2*STAMP_W-1:STAMP_W];
            phase_nxt                  = PH_COMPLETE;
            fresh_nxt[active_r]        = 1'b1;
            out_item_nxt.done_valid    = 1'b1;
            out_item_nxt.done_channel  = active_ext[CHSEL_W-1:0];
            out_item_nxt.done_distance = echo_prod[2*STAMP_W-1:STAMP_W];
          end
        end
      end
      OP_POLL: begin
        if (seq_active_r) begin
          // timeout while still waiting on the echo
          if (((phase_r == PH_WAIT_START) || (phase_r == PH_WAIT_END)) &&
              (elapsed > timeout_r)) begin
            dist_we                    = 1'b1;
            dist_wdata                 = DIST_UNKNOWN;
            fresh_nxt[active_r]        = 1'b1;
            out_item_nxt.done_valid    = 1'b1;
            out_item_nxt.done_channel  = active_ext[CHSEL_W-1:0];
            out_item_nxt.done_distance = DIST_UNKNOWN;
            out_item_nxt.done_timeout  = 1'b1;
            phase_nxt                  = PH_TIMEOUT;
          end
          // finished channel: move on or end the run
          if ((phase_r == PH_COMPLETE) || (phase_r == PH_TIMEOUT) ||
              out_item_nxt.done_timeout) begin
            if (last_ch) begin
              seq_active_nxt = 1'b0;
            end else begin
              active_nxt                   = next_ch;
              phase_nxt                    = PH_WAIT_START;
              fresh_nxt[next_ch]           = 1'b0;
              trig_stamp_nxt               = s1_item_r.now;
              out_item_nxt.trigger_fire    = 1'b1;
              out_item_nxt.trigger_channel = next_ext[CHSEL_W-1:0];
            end
          end
        end
      end
      OP_READ: begin
        if (ch_in_range) begin
          out_item_nxt.read_distance = dist_r[ch_idx];
          out_item_nxt.read_fresh    = fresh_r[ch_idx];
        end else begin
          out_item_nxt.read_distance = DIST_UNKNOWN;
          out_item_nxt.read_fresh    = 1'b0;
        end
      end
      default: begin
        out_item_nxt = '0;
      end
    endcase

    out_item_nxt.running = seq_active_nxt;
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      active_r     <= '0;
      seq_active_r <= 1'b0;
      trig_stamp_r <= '0;
      echo_stamp_r <= '0;
      fresh_r      <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      seq_active_r <= seq_active_nxt;
      trig_stamp_r <= trig_stamp_nxt;
      echo_stamp_r <= echo_stamp_nxt;
      fresh_r      <= fresh_nxt;
    end
  end

  // stored distances, written for the active channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        dist_r[i] <= DIST_UNKNOWN;
      end
    end else if (advance && dist_we) begin
      dist_r[active_r] <= dist_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

[sim/tb_top.sv]
// testbench for the ultrasonic ranging sequencer core: directed, config and random traffic
`timescale 1ns / 1ps

module tb_top;
  import urs_pkg::*;

  localparam int unsigned NCH = 4;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  // tdata: channel[1:0], level[2], now[18:3], zero fill
  logic [IN_TDATA_W-1:0]  in_tdata;
  // tuser: operation[1:0]
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // tdata: trigger_fire[0], trigger_channel[2:1], done_valid[3], done_channel[5:4],
  // done_distance[21:6], done_timeout[22], running[23], read_distance[39:24],
  // read_fresh[40], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predicted sequencer state and register copies
  phase_t          ch_phase [NCH];
  logic [15:0]     ch_dist  [NCH];
  logic            ch_fresh [NCH];
  logic [15:0]     echo_t0  [NCH];
  int unsigned     cur_ch;
  logic            seq_on;
  logic [15:0]     trig_t0;
  logic [15:0]     tmo_ticks;
  logic [15:0]     scale_q16;

  // results still owed by the block, oldest first
  out_item_t       result_q [$];

  logic            calm;
  int unsigned     n_items, n_results, n_mismatch, n_cfg;
  int unsigned     n_trig, n_echo, n_tmo, n_reads;

  ultrasonic_ranging_sequencer_core #(
    .CHANNELS(NCH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // arm a channel: wait for echo start and fire its trigger
  function automatic void arm_ranging_channel(int unsigned c, logic [15:0] t,
                                              inout out_item_t r);
    ch_phase[c] = PH_WAIT_START;
    ch_fresh[c] = 1'b0;
    echo_t0[c] = 16'h0000;
    trig_t0 = t;
    r.trigger_fire = 1'b1;
    r.trigger_channel = 2'(c);
  endfunction

  // expected result of one item, updates the predicted state
  function automatic out_item_t predict_ranging(in_item_t it);
    out_item_t   r;
    logic [15:0] width;
    logic [15:0] elapsed;
    logic [31:0] prod;
    phase_t      ph;
    int unsigned c;
    r = '0;
    c = 32'(it.channel);
    case (it.operation)
      OP_START: begin
        cur_ch = 0;
        seq_on = 1'b1;
        for (int i = 0; i < NCH; i++) begin
          ch_phase[i] = PH_IDLE;
          ch_fresh[i] = 1'b0;
        end
        arm_ranging_channel(0, it.now, r);
      end
      OP_EDGE: begin
        // only the active channel in the matching phase counts
        if (seq_on && c < NCH && c == cur_ch) begin
          if (it.level) begin
            if (ch_phase[c] == PH_WAIT_START) begin
              echo_t0[c] = it.now;
              ch_phase[c] = PH_WAIT_END;
            end
          end else if (ch_phase[c] == PH_WAIT_END) begin
            width = it.now - echo_t0[c];
            prod = width * scale_q16;
            ch_dist[c] = prod[31:16];
            ch_phase[c] = PH_COMPLETE;
            ch_fresh[c] = 1'b1;
            r.done_valid = 1'b1;
            r.done_channel = 2'(c);
            r.done_distance = ch_dist[c];
          end
        end
      end
      OP_POLL: begin
        if (seq_on && cur_ch < NCH) begin
          ph = ch_phase[cur_ch];
          // wrap-around timeout check while the measurement is open
          if (ph == PH_WAIT_START || ph == PH_WAIT_END) begin
            elapsed = it.now - trig_t0;
            if (elapsed > tmo_ticks) begin
              ch_phase[cur_ch] = PH_TIMEOUT;
              ch_dist[cur_ch] = DIST_UNKNOWN;
              ch_fresh[cur_ch] = 1'b1;
              r.done_valid = 1'b1;
              r.done_channel = 2'(cur_ch);
              r.done_distance = DIST_UNKNOWN;
              r.done_timeout = 1'b1;
              ph = PH_TIMEOUT;
            end
          end
          // advance to the next channel or end the sequence
          if (ph == PH_COMPLETE || ph == PH_TIMEOUT) begin
            if (cur_ch + 1 >= NCH) begin
              seq_on = 1'b0;
            end else begin
              cur_ch = cur_ch + 1;
              arm_ranging_channel(cur_ch, it.now, r);
            end
          end
        end
      end
      default: begin
        if (c < NCH) begin
          r.read_distance = ch_dist[c];
          r.read_fresh = ch_fresh[c];
        end else begin
          r.read_distance = DIST_UNKNOWN;
          r.read_fresh = 1'b0;
        end
      end
    endcase
    r.running = seq_on;
    return r;
  endfunction

  // count and report one wrong field
  function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
               n_results, what, want, got);
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_item_t'(out_tdata[$bits(out_item_t)-1:0]);
      if (result_q.size() == 0) begin
        flag_mismatch("transfer with no result pending", 0, 32'(got));
      end else begin
        want = result_q.pop_front();
        if (got.trigger_fire != want.trigger_fire)
          flag_mismatch("trigger_fire", 32'(want.trigger_fire), 32'(got.trigger_fire));
        if (got.trigger_channel != want.trigger_channel)
          flag_mismatch("trigger_channel", 32'(want.trigger_channel),
                        32'(got.trigger_channel));
        if (got.done_valid != want.done_valid)
          flag_mismatch("done_valid", 32'(want.done_valid), 32'(got.done_valid));
        if (got.done_channel != want.done_channel)
          flag_mismatch("done_channel", 32'(want.done_channel), 32'(got.done_channel));
        if (got.done_distance != want.done_distance)
          flag_mismatch("done_distance", 32'(want.done_distance), 32'(got.done_distance));
        if (got.done_timeout != want.done_timeout)
          flag_mismatch("done_timeout", 32'(want.done_timeout), 32'(got.done_timeout));
        if (got.running != want.running)
          flag_mismatch("running", 32'(want.running), 32'(got.running));
        if (got.read_distance != want.read_distance)
          flag_mismatch("read_distance", 32'(want.read_distance), 32'(got.read_distance));
        if (got.read_fresh != want.read_fresh)
          flag_mismatch("read_fresh", 32'(want.read_fresh), 32'(got.read_fresh));
      end
      n_results++;
    end
  end

  // result side backpressure in random bursts
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // send one item, valid stays high after the transfer until the next call
  task automatic send_item(op_t op, logic [1:0] ch, logic lvl, logic [15:0] t);
    in_item_t  it;
    out_item_t r;
    it.operation = op;
    it.channel = ch;
    it.level = lvl;
    it.now = t;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, it.now, it.level, it.channel};
    in_tuser <= it.operation;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_ranging(it);
    result_q.push_back(r);
    n_items++;
    if (r.trigger_fire) n_trig++;
    if (r.done_valid && !r.done_timeout) n_echo++;
    if (r.done_timeout) n_tmo++;
    if (op == OP_READ) n_reads++;
  endtask

  task automatic send_noise();
    send_item(op_t'($urandom_range(0, 3)), 2'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // drop valid and wait until every result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // write both registers while the block is idle
  task automatic set_config(logic [15:0] tmo, logic [15:0] scale);
    drain_results();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_addr <= CFG_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    tmo_ticks = tmo;
    scale_q16 = scale;
    n_cfg += 2;
  endtask

  // one mostly well formed ranging sequence with random timing
  task automatic run_ranging_pass();
    logic [15:0] t;
    int unsigned width;
    t = 16'($urandom);
    send_item(OP_START, 2'($urandom), 1'($urandom), t);
    for (int c = 0; c < NCH; c++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      // occasionally abandon the sequence midway
      if ($urandom_range(0, 15) == 0) return;
      if ($urandom_range(0, 3) == 0 && tmo_ticks != 16'hFFFF) begin
        // no echo end: poll past the timeout
        if ($urandom_range(0, 1))
          send_item(OP_EDGE, 2'(c), 1'b1, trig_t0 + 16'($urandom_range(0, tmo_ticks)));
        send_item(OP_POLL, 2'($urandom), 1'($urandom),
                  trig_t0 + 16'($urandom_range(tmo_ticks + 1, 65535)));
      end else begin
        if ($urandom_range(0, 1))
          send_item(OP_POLL, 2'($urandom), 1'($urandom),
                    trig_t0 + 16'($urandom_range(0, tmo_ticks)));
        t = trig_t0 + 16'($urandom_range(0, 2000));
        send_item(OP_EDGE, 2'(c), 1'b1, t);
        width = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 30000);
        if ($urandom_range(0, 4) == 0)
          send_item(OP_EDGE, 2'(c), 1'b1, t + 16'($urandom_range(0, 100)));
        send_item(OP_EDGE, 2'(c), 1'b0, t + 16'(width));
        if ($urandom_range(0, 2) == 0)
          send_item(OP_READ, 2'(c), 1'($urandom), 16'($urandom));
        send_item(OP_POLL, 2'($urandom), 1'($urandom), t + 16'(width) + 16'($urandom));
      end
    end
    send_item(OP_READ, 2'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // edges, polls and reads with no sequence running
  task automatic test_idle_behavior();
    send_item(OP_READ, 2'd0, 1'b0, 16'h0000);
    send_item(OP_READ, 2'd3, 1'b1, 16'hFFFF);
    send_item(OP_EDGE, 2'd0, 1'b1, 16'h1234);
    send_item(OP_POLL, 2'd2, 1'b0, 16'hFFFF);
  endtask

  // hand-picked sequence through every phase and corner at reset config
  task automatic test_directed_sequence();
    send_item(OP_START, 2'd3, 1'b1, 16'hFFF0);
    // wrong channel, then falling edge before any rising edge
    send_item(OP_EDGE, 2'd1, 1'b1, 16'hFFF2);
    send_item(OP_EDGE, 2'd0, 1'b0, 16'hFFF4);
    // echo that wraps the timer, with a repeated rising edge
    send_item(OP_EDGE, 2'd0, 1'b1, 16'hFFFF);
    send_item(OP_EDGE, 2'd0, 1'b1, 16'h0010);
    send_item(OP_EDGE, 2'd0, 1'b0, 16'h0100);
    send_item(OP_EDGE, 2'd0, 1'b0, 16'h0200);
    send_item(OP_READ, 2'd0, 1'b0, 16'h0250);
    // completed channel advances and fires the trigger of channel 1, then timeout on channel 1
    send_item(OP_POLL, 2'd0, 1'b0, 16'h0300);
    send_item(OP_POLL, 2'd1, 1'b0, 16'h0300 + 16'd40000);
    send_item(OP_POLL, 2'd1, 1'b0, 16'h0300 + 16'd40001);
    send_item(OP_READ, 2'd1, 1'b1, 16'h0000);
    // restart keeps distances and clears fresh flags
    send_item(OP_START, 2'd0, 1'b0, 16'h0000);
    send_item(OP_READ, 2'd0, 1'b0, 16'h0000);
    send_item(OP_POLL, 2'd0, 1'b1, 16'hFFFF);
    send_item(OP_POLL, 2'd2, 1'b0, 16'h9C40);
    send_item(OP_POLL, 2'd3, 1'b1, 16'h3881);
    // zero width echo on the last channel, then the sequence ends
    send_item(OP_EDGE, 2'd3, 1'b1, 16'h3900);
    send_item(OP_EDGE, 2'd3, 1'b0, 16'h3900);
    send_item(OP_POLL, 2'd3, 1'b0, 16'h3A00);
    send_item(OP_POLL, 2'd0, 1'b0, 16'hFFFF);
    send_item(OP_READ, 2'd3, 1'b1, 16'h0000);
  endtask

  // register extremes: zero and full timeout, zero and full scale
  task automatic test_config_extremes();
    set_config(16'h0000, 16'hFFFF);
    send_item(OP_START, 2'd0, 1'b0, 16'h1000);
    send_item(OP_POLL, 2'd0, 1'b0, 16'h1000);
    send_item(OP_EDGE, 2'd0, 1'b1, 16'h0000);
    send_item(OP_EDGE, 2'd0, 1'b0, 16'hFFFF);
    send_item(OP_POLL, 2'd0, 1'b0, 16'h2000);
    send_item(OP_POLL, 2'd1, 1'b0, 16'h2001);
    set_config(16'hFFFF, 16'h0000);
    send_item(OP_START, 2'd2, 1'b1, 16'h8000);
    send_item(OP_POLL, 2'd0, 1'b0, 16'h7FFF);
    send_item(OP_EDGE, 2'd0, 1'b1, 16'h8001);
    send_item(OP_EDGE, 2'd0, 1'b0, 16'h7000);
    send_item(OP_READ, 2'd0, 1'b0, 16'h0000);
  endtask

  // random sequences and noise across several register settings
  task automatic test_random_traffic();
    int unsigned base;
    base = n_items;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(TIMEOUT_RST, SCALE_RST);
        1: set_config(16'($urandom_range(0, 3000)), 16'($urandom));
        2: set_config(16'hFFFF, 16'hFFFF);
        3: set_config(16'h0000, 16'h0000);
        default: set_config(16'($urandom), 16'($urandom));
      endcase
      while (n_items - base < (ph + 1) * 90) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else run_ranging_pass();
        // last stretch runs without idling on either side
        if (n_items - base > 390) calm = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_TIMEOUT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_START;
    calm = 1'b0;
    n_items = 0;
    n_results = 0;
    n_mismatch = 0;
    n_cfg = 0;
    n_trig = 0;
    n_echo = 0;
    n_tmo = 0;
    n_reads = 0;
    // predicted state after reset
    for (int i = 0; i < NCH; i++) begin
      ch_phase[i] = PH_IDLE;
      ch_dist[i] = DIST_UNKNOWN;
      ch_fresh[i] = 1'b0;
      echo_t0[i] = 16'h0000;
    end
    cur_ch = 0;
    seq_on = 1'b0;
    trig_t0 = 16'h0000;
    tmo_ticks = TIMEOUT_RST;
    scale_q16 = SCALE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_behavior();
    test_directed_sequence();
    test_config_extremes();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    $display("run covered %0d items, %0d results, %0d register writes",
             n_items, n_results, n_cfg);
    $display("  %0d triggers, %0d echo distances, %0d timeouts, %0d reads, %0d mismatches",
             n_trig, n_echo, n_tmo, n_reads, n_mismatch);
    if (n_mismatch == 0 && result_q.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
